@@ hdl/multi_table_value_set_assert.svh @@
// assertion macros for the checker file of multi_table_value_set
// no other dependencies
`ifndef MULTI_TABLE_VALUE_SET_ASSERT_SVH
`define MULTI_TABLE_VALUE_SET_ASSERT_SVH

// same-cycle implication
`define MTVS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtvs check failed");

// next-cycle implication
`define MTVS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtvs check failed");

`endif

@@ hdl/mtvs_pkg.sv @@
// types, codes and sizes for the multi table value set block
// no dependencies
`timescale 1ns / 1ps

package mtvs_pkg;

   localparam int NUM_TABLES  = 4;
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int TAB_W       = $clog2(NUM_TABLES);
   localparam int ADDR_W      = TAB_W + IDX_W;
   localparam int ENTRIES     = NUM_TABLES * TABLE_DEPTH;
   localparam int CNT_W       = 5;
   localparam int VAL_W       = 32;
   localparam int NUM_CSR     = 4;
   localparam int CSR_W       = 2;

   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET  = 5'd16;
   localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

   localparam logic [2:0] FUNC_CLEAR  = 3'd0;
   localparam logic [2:0] FUNC_INSERT = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_FIND   = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_PRESENT   = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [2:0]        func;
      logic [1:0]        table_sel;
      logic signed [31:0] item_value;
      logic [3:0]        entry_index;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [3:0]        found_index;
      logic [2:0]        status;
      logic [4:0]        entry_count;
   } rsp_payload_type;

   // commands from the sequencer to the entry store
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic              kill_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              clr_en;
      logic [TAB_W-1:0]  clr_tab;
      logic [CNT_W-1:0]  clr_cap;
   } store_cmd_type;

endpackage

@@ hdl/mtvs_store.sv @@
// entry store: one synchronous memory for all tables plus a valid bit per entry
// depends on mtvs_pkg
`timescale 1ns / 1ps

module mtvs_store import mtvs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  store_cmd_type    cmd,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0]   mem [ENTRIES];
   logic [VAL_W-1:0]   mem_q_ff;
   logic               vld_q_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[cmd.rd_addr];
         vld_q_ff <= valid_ff[cmd.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
      if (cmd.kill_en) begin
         valid_in[cmd.wr_addr] = 1'b0;
      end
      // clear drops the valid bits of the first capacity entries of one table
      if (cmd.clr_en) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) < cmd.clr_cap) begin
               valid_in[{cmd.clr_tab, IDX_W'(i)}] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // an entry never written reads as empty
   assign rd_data = vld_q_ff ? mem_q_ff : EMPTY_MARK;

endmodule

@@ hdl/multi_table_value_set.sv @@
// Four set tables of sixteen signed 32-bit entries each, all held in one
// single-port-read memory with a valid bit per entry, so reset empties every
// table at once with no clearing pass. A request is taken only while the
// sequencer is idle. Insert, remove and find read the table's first capacity
// entries one per cycle through the memory read port; read fetches the entry
// it names. A scan ends in a drain state and then finish; clear and requests
// needing no memory access go straight to finish. A finished response sits
// in an output register, so the next request can be taken while it waits.
// depends on mtvs_pkg and mtvs_store
`timescale 1ns / 1ps

module multi_table_value_set import mtvs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  logic [CSR_W-1:0] csr_addr,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [2:0]       op_ff, op_in;
   logic [TAB_W-1:0] tab_ff, tab_in;
   logic             tab_bad_ff, tab_bad_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [3:0]       idx_ff, idx_in;
   logic [CNT_W-1:0] cap_ff, cap_in;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             empty_ff, empty_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic [VAL_W-1:0] rdval_ff, rdval_in;

   logic [CNT_W-1:0] cap_reg_ff [NUM_CSR];
   logic [CNT_W-1:0] cap_reg_in [NUM_CSR];
   logic [CNT_W-1:0] count_ff [NUM_TABLES];
   logic [CNT_W-1:0] count_in [NUM_TABLES];

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   store_cmd_type    cmd;
   logic [VAL_W-1:0] rd_data;

   logic             accept;
   logic [CNT_W-1:0] cap_sel;
   logic [CNT_W-1:0] cap_eff;
   logic             acc_bad;
   logic             need_scan;
   logic [IDX_W-1:0] scan_idx;
   logic             scan_last;
   logic             fin_fire;
   rsp_payload_type  res;
   logic [CNT_W-1:0] cur_cnt;
   logic [CNT_W-1:0] new_cnt;
   logic             do_wr, do_kill, do_clr;

   mtvs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // request decode at accept
   always_comb begin
      cap_sel = cap_reg_ff[req_data.table_sel];
      cap_eff = (cap_sel > DEPTH_CNT) ? DEPTH_CNT : cap_sel;
      acc_bad = int'(req_data.table_sel) >= NUM_TABLES;
      case (req_data.func)
         FUNC_INSERT, FUNC_REMOVE, FUNC_FIND: need_scan = (cap_eff != '0);
         FUNC_READ: need_scan = CNT_W'(req_data.entry_index) < cap_eff;
         default:   need_scan = 1'b0;
      endcase
      need_scan = need_scan && !acc_bad;
   end

   assign scan_idx  = (op_ff == FUNC_READ) ? IDX_W'(idx_ff) : cnt_ff;
   assign scan_last = (op_ff == FUNC_READ) || (CNT_W'(cnt_ff) == cap_ff - 1'b1);
   assign fin_fire  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // result and write-back of the finished request
   always_comb begin
      res     = '0;
      do_wr   = 1'b0;
      do_kill = 1'b0;
      do_clr  = 1'b0;
      cur_cnt = count_ff[tab_ff];
      new_cnt = cur_cnt;
      if (tab_bad_ff) begin
         res.status = ST_RANGE;
      end else begin
         case (op_ff)
            FUNC_CLEAR: begin
               new_cnt = '0;
               do_clr  = 1'b1;
            end
            FUNC_INSERT: begin
               if (match_ff) begin
                  res.status = ST_PRESENT;
               end else if (cur_cnt >= cap_ff || !empty_ff) begin
                  res.status = ST_FULL;
               end else begin
                  do_wr   = 1'b1;
                  new_cnt = cur_cnt + 1'b1;
               end
            end
            FUNC_REMOVE: begin
               // removing the empty mark is ignored
               if (val_ff == EMPTY_MARK || !match_ff) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  do_kill = 1'b1;
                  if (cur_cnt != '0) begin
                     new_cnt = cur_cnt - 1'b1;
                  end
               end
            end
            FUNC_FIND: begin
               if (!match_ff) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  res.found_index = 4'(match_idx_ff);
               end
            end
            FUNC_READ: begin
               if (CNT_W'(idx_ff) >= cap_ff) begin
                  res.status = ST_RANGE;
               end else begin
                  res.read_value = rdval_ff;
               end
            end
            default: ;
         endcase
         res.entry_count = new_cnt;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.rd_en   = (state_ff == S_SCAN);
      cmd.rd_addr = {tab_ff, scan_idx};
      cmd.wr_en   = fin_fire && do_wr;
      cmd.kill_en = fin_fire && do_kill;
      cmd.wr_addr = do_wr ? {tab_ff, empty_idx_ff} : {tab_ff, match_idx_ff};
      cmd.wr_data = val_ff;
      cmd.clr_en  = fin_fire && do_clr;
      cmd.clr_tab = tab_ff;
      cmd.clr_cap = cap_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tab_in       = tab_ff;
      tab_bad_in   = tab_bad_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      cap_in       = cap_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      rdval_in     = rdval_ff;
      count_in     = count_ff;
      cap_reg_in   = cap_reg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         cap_reg_in[csr_addr] = csr_wdata;
      end

      // compare the entry that came back from the memory
      if (pend_ff) begin
         rdval_in = rd_data;
         if (rd_data == val_ff && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = pidx_ff;
         end
         if (rd_data == EMPTY_MARK && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = pidx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_data.func;
               tab_in     = TAB_W'(req_data.table_sel);
               tab_bad_in = acc_bad;
               val_in     = req_data.item_value;
               idx_in     = req_data.entry_index;
               cap_in     = cap_eff;
               cnt_in     = '0;
               match_in   = 1'b0;
               empty_in   = 1'b0;
               state_in   = need_scan ? S_SCAN : S_FIN;
            end
         end
         S_SCAN: begin
            pend_in = 1'b1;
            pidx_in = scan_idx;
            cnt_in  = cnt_ff + 1'b1;
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
               if (!tab_bad_ff) begin
                  count_in[tab_ff] = new_cnt;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         match_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CSR; i++) begin
            cap_reg_ff[i] <= CAP_RESET;
         end
         for (int i = 0; i < NUM_TABLES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         match_ff     <= match_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_reg_ff   <= cap_reg_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tab_ff       <= tab_in;
      tab_bad_ff   <= tab_bad_in;
      val_ff       <= val_in;
      idx_ff       <= idx_in;
      cap_ff       <= cap_in;
      cnt_ff       <= cnt_in;
      pidx_ff      <= pidx_in;
      match_idx_ff <= match_idx_in;
      empty_idx_ff <= empty_idx_in;
      rdval_ff     <= rdval_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

@@ hdl/mtvs_checker.sv @@
// port-level checks for multi_table_value_set, bound to the top level
// depends on mtvs_pkg and multi_table_value_set_assert.svh
`timescale 1ns / 1ps
`include "multi_table_value_set_assert.svh"

module mtvs_port_checker import mtvs_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // requests taken whose response has not been delivered
   logic [1:0] pend_ff, pend_in;
   logic       rsp_stall;
   logic       rsp_fail;
   logic       rsp_zero;

   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) begin
         pend_in = pend_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pend_in = pend_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_fail  = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_zero  = (rsp_data.read_value == 0) && (rsp_data.found_index == 4'd0);

   `MTVS_ASSERT_NOW(a_rsp_has_request, clock, reset, rsp_valid, pend_ff != 2'd0)
   `MTVS_ASSERT_NOW(a_one_waiting, clock, reset, req_ready, pend_ff <= 2'd1)
   `MTVS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `MTVS_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, rsp_zero)
   `MTVS_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_data.entry_count <= DEPTH_CNT)

endmodule

bind multi_table_value_set mtvs_port_checker u_mtvs_checker (.*);
